@@ design/oaci_pkg.sv @@
// Shared types, constants and helper functions for the octree box cell index block.
// No dependencies; the interface, lane, merge and top-level files use this package.
package oaci_pkg;

  localparam int MAX_DEPTH = 7;
  localparam int NUM_AXES  = 3;
  localparam int NUM_LANES = 2 * NUM_AXES;
  localparam int COORD_W   = 32;
  localparam int CODE_W    = 3 * MAX_DEPTH;
  localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1);
  localparam int INDEX_W   = 22;
  localparam int LEVEL_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_STAGES = 4;

  typedef logic [MAX_DEPTH-1:0] cell_t;
  typedef logic [CODE_W-1:0]    code_t;
  typedef logic [DEPTH_W-1:0]   depth_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_ORIGIN_Z   = 3'd2,
    REG_SCALE_X    = 3'd3,
    REG_SCALE_Y    = 3'd4,
    REG_SCALE_Z    = 3'd5,
    REG_TREE_DEPTH = 3'd6
  } cfg_reg_e;

  // Per-stage load strobes for the lane pipeline
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } lane_ctl_t;

  // Interleave three cell numbers: x in bit 0, y in bit 1, z in bit 2 of each group
  function automatic code_t morton3(input cell_t x, input cell_t y, input cell_t z);
    code_t m;
    m = '0;
    for (int b = 0; b < MAX_DEPTH; b++) begin
      m[3*b]     = x[b];
      m[3*b + 1] = y[b];
      m[3*b + 2] = z[b];
    end
    return m;
  endfunction

  // Cells on all levels coarser than level k: (8^k - 1) / 7, built as a sum of powers of 8
  function automatic logic [31:0] coarse_cells(input depth_t k);
    logic [31:0] acc;
    acc = '0;
    for (int j = 0; j < MAX_DEPTH; j++) begin
      if (j < int'(k)) acc = acc | (32'd1 << (3 * j));
    end
    return acc;
  endfunction

endpackage

@@ design/oaci_ifs.sv @@
// Valid/ready channel interfaces: box input, cell index result and configuration write.
// Depends on oaci_pkg for the register index width.
interface oaci_box_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] lo_x;
  logic signed [31:0] lo_y;
  logic signed [31:0] lo_z;
  logic signed [31:0] hi_x;
  logic signed [31:0] hi_y;
  logic signed [31:0] hi_z;
  modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
  modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

interface oaci_idx_if;
  logic        valid;
  logic        ready;
  logic [21:0] cell_index;
  logic [2:0]  levels_up;
  logic        index_valid;
  modport source (output valid, cell_index, levels_up, index_valid, input ready);
  modport sink   (input valid, cell_index, levels_up, index_valid, output ready);
endinterface

interface oaci_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [oaci_pkg::CFG_IDX_W-1:0] index;
  logic [31:0]                    data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/oaci_lane.sv @@
// One coordinate lane: subtract origin, scale to grid units, bound-check the cell.
// Depends on oaci_pkg.
module oaci_lane (
  input  logic                      clk,
  input  oaci_pkg::lane_ctl_t       ctl,
  input  logic signed [31:0]        coord,
  input  logic signed [31:0]        origin,
  input  logic [31:0]               scale,
  input  logic [oaci_pkg::DEPTH_W-1:0] depth,
  output oaci_pkg::cell_t           cell_num,
  output logic                      cell_ok
);
  import oaci_pkg::*;

  logic [32:0] diff;
  logic        neg1_r, neg1_nxt;
  logic [31:0] mag1_r, mag1_nxt;
  logic        neg2_r, neg2_nxt;
  logic [63:0] prod2_r, prod2_nxt;
  logic [31:0] cell_full;
  logic [31:0] low_mask;
  cell_t       cell3_r, cell3_nxt;
  logic        ok3_r, ok3_nxt;

  // Stage 1: 33-bit signed difference, sign marks a corner below the origin
  assign diff     = {coord[31], coord} - {origin[31], origin};
  assign neg1_nxt = diff[32];
  assign mag1_nxt = diff[31:0];

  // Stage 2: Q16.16 times Q16.16, integer part sits in the upper word
  assign neg2_nxt  = neg1_r;
  assign prod2_nxt = 64'(mag1_r) * 64'(scale);

  // Stage 3: cell must be non-negative and stay below 2^depth
  assign cell_full = prod2_r[63:32];
  assign low_mask  = (32'd1 << depth) - 32'd1;
  assign cell3_nxt = cell_full[MAX_DEPTH-1:0];
  assign ok3_nxt   = !neg2_r && ((cell_full & ~low_mask) == 32'd0);

  always_ff @(posedge clk) begin
    if (ctl.ld1) begin
      neg1_r <= neg1_nxt;
      mag1_r <= mag1_nxt;
    end
    if (ctl.ld2) begin
      neg2_r  <= neg2_nxt;
      prod2_r <= prod2_nxt;
    end
    if (ctl.ld3) begin
      cell3_r <= cell3_nxt;
      ok3_r   <= ok3_nxt;
    end
  end

  assign cell_num = cell3_r;
  assign cell_ok  = ok3_r;

endmodule

@@ design/oaci_merge.sv @@
// Merge stage: Morton codes of both corners, level search and linear cell index.
// Depends on oaci_pkg.
module oaci_merge (
  input  logic                         clk,
  input  logic                         ld,
  input  oaci_pkg::cell_t              cells [oaci_pkg::NUM_LANES],
  input  logic [oaci_pkg::NUM_LANES-1:0] cell_ok,
  input  logic [oaci_pkg::DEPTH_W-1:0] depth,
  output logic [oaci_pkg::INDEX_W-1:0] cell_index,
  output logic [oaci_pkg::LEVEL_W-1:0] levels_up,
  output logic                         index_valid
);
  import oaci_pkg::*;

  code_t       lo_code, hi_code, diff_code, coarse_code;
  depth_t      up;
  logic [31:0] sum;
  logic [INDEX_W-1:0] index_r, index_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               valid_r, valid_nxt;

  assign lo_code   = morton3(cells[0], cells[1], cells[2]);
  assign hi_code   = morton3(cells[3], cells[4], cells[5]);
  assign diff_code = lo_code ^ hi_code;

  // Highest differing group below the depth sets the climb
  always_comb begin
    up = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((i < int'(depth)) && (diff_code[3*i +: 3] != 3'd0)) up = DEPTH_W'(i + 1);
    end
  end

  assign coarse_code = hi_code >> (3 * up);
  assign sum         = 32'(coarse_code) + coarse_cells(depth - up);

  always_comb begin
    if (&cell_ok) begin
      index_nxt = sum[INDEX_W-1:0];
      level_nxt = LEVEL_W'(up);
      valid_nxt = 1'b1;
    end else begin
      index_nxt = '0;
      level_nxt = '0;
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      index_r <= index_nxt;
      level_r <= level_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign cell_index  = index_r;
  assign levels_up   = level_r;
  assign index_valid = valid_r;

endmodule

@@ design/octree_aabb_cell_index.sv @@
// Top level of the octree box cell index block: configuration registers, six lanes, merge.
// Depends on oaci_pkg, oaci_ifs, oaci_lane and oaci_merge.
//
//  channel   dir   transfer when          carries
//  in_box    in    valid && ready         lo_x lo_y lo_z hi_x hi_y hi_z (signed Q16.16)
//  out_idx   out   valid && ready         cell_index[21:0] levels_up[2:0] index_valid
//  cfg_wr    in    valid && ready         index[2:0] data[31:0], ready tied high
//
// One box per clock sustained while out_idx is ready; each result passes through four
// register stages before it is presented (lane subtract, lane multiply, lane bound check,
// merge into the output register). The six lanes hold the three axes of both corners
// side by side.
// Every stage has its own valid bit and takes a new item when it is empty or its
// successor moves, so bubbles close up and input keeps flowing while a result waits, until every stage is full.
// Synchronous active-low reset empties the pipe and loads the register defaults;
// no clearing pass is needed.
module octree_aabb_cell_index (
  input  logic        clk,
  input  logic        rst_n,
  oaci_box_if.sink    in_box,
  oaci_idx_if.source  out_idx,
  oaci_cfg_if.sink    cfg_wr
);
  import oaci_pkg::*;

  logic signed [31:0] origin_x_r, origin_y_r, origin_z_r;
  logic signed [31:0] origin_x_nxt, origin_y_nxt, origin_z_nxt;
  logic [31:0]        scale_x_r, scale_y_r, scale_z_r;
  logic [31:0]        scale_x_nxt, scale_y_nxt, scale_z_nxt;
  logic [2:0]         tree_depth_r, tree_depth_nxt;
  depth_t             eff_depth;

  logic [NUM_STAGES-1:0] vld_r, vld_nxt, rdy, ld;
  lane_ctl_t             lane_ctl;

  logic signed [31:0] lane_coord  [NUM_LANES];
  logic signed [31:0] axis_origin [NUM_AXES];
  logic [31:0]        axis_scale  [NUM_AXES];
  cell_t              lane_cell   [NUM_LANES];
  logic [NUM_LANES-1:0] lane_ok;

  // Configuration writes; the port never back-pressures
  assign cfg_wr.ready = 1'b1;

  always_comb begin
    origin_x_nxt   = origin_x_r;
    origin_y_nxt   = origin_y_r;
    origin_z_nxt   = origin_z_r;
    scale_x_nxt    = scale_x_r;
    scale_y_nxt    = scale_y_r;
    scale_z_nxt    = scale_z_r;
    tree_depth_nxt = tree_depth_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        REG_ORIGIN_X:   origin_x_nxt   = cfg_wr.data;
        REG_ORIGIN_Y:   origin_y_nxt   = cfg_wr.data;
        REG_ORIGIN_Z:   origin_z_nxt   = cfg_wr.data;
        REG_SCALE_X:    scale_x_nxt    = cfg_wr.data;
        REG_SCALE_Y:    scale_y_nxt    = cfg_wr.data;
        REG_SCALE_Z:    scale_z_nxt    = cfg_wr.data;
        REG_TREE_DEPTH: tree_depth_nxt = cfg_wr.data[2:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      origin_z_r   <= '0;
      scale_x_r    <= 32'd65536;
      scale_y_r    <= 32'd65536;
      scale_z_r    <= 32'd65536;
      tree_depth_r <= 3'd3;
    end else begin
      origin_x_r   <= origin_x_nxt;
      origin_y_r   <= origin_y_nxt;
      origin_z_r   <= origin_z_nxt;
      scale_x_r    <= scale_x_nxt;
      scale_y_r    <= scale_y_nxt;
      scale_z_r    <= scale_z_nxt;
      tree_depth_r <= tree_depth_nxt;
    end
  end

  // Clamp the configured depth to what the datapath is built for
  assign eff_depth = (32'(tree_depth_r) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH)
                                                     : DEPTH_W'(tree_depth_r);

  // Pipeline flow: a stage advances when empty or when its successor advances
  always_comb begin
    rdy[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_idx.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld[0]      = rdy[0] && in_box.valid;
    vld_nxt[0] = rdy[0] ? in_box.valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      ld[k]      = rdy[k] && vld_r[k-1];
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_box.ready = rdy[0];
  assign lane_ctl     = '{ld1: ld[0], ld2: ld[1], ld3: ld[2]};

  // Lanes 0..2 take the minimum corner, 3..5 the maximum, axis order x, y, z
  assign lane_coord[0] = in_box.lo_x;
  assign lane_coord[1] = in_box.lo_y;
  assign lane_coord[2] = in_box.lo_z;
  assign lane_coord[3] = in_box.hi_x;
  assign lane_coord[4] = in_box.hi_y;
  assign lane_coord[5] = in_box.hi_z;

  assign axis_origin[0] = origin_x_r;
  assign axis_origin[1] = origin_y_r;
  assign axis_origin[2] = origin_z_r;
  assign axis_scale[0]  = scale_x_r;
  assign axis_scale[1]  = scale_y_r;
  assign axis_scale[2]  = scale_z_r;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    oaci_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .coord    (lane_coord[g]),
      .origin   (axis_origin[g % NUM_AXES]),
      .scale    (axis_scale[g % NUM_AXES]),
      .depth    (eff_depth),
      .cell_num (lane_cell[g]),
      .cell_ok  (lane_ok[g])
    );
  end

  // Merge lands straight in the output register
  oaci_merge u_merge (
    .clk         (clk),
    .ld          (ld[NUM_STAGES-1]),
    .cells       (lane_cell),
    .cell_ok     (lane_ok),
    .depth       (eff_depth),
    .cell_index  (out_idx.cell_index),
    .levels_up   (out_idx.levels_up),
    .index_valid (out_idx.index_valid)
  );

  assign out_idx.valid = vld_r[NUM_STAGES-1];

endmodule

@@ design/oaci_checker.sv @@
// Port-level checks for the octree box cell index block, bound to its top level.
// Depends on the top level's interface ports only.
module oaci_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [21:0] cell_index,
  input logic [2:0]  levels_up,
  input logic        index_valid,
  input logic        cfg_ready
);

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cell_index) &&
    $stable(levels_up) && $stable(index_valid))
    else $error("stalled result changed or dropped");

  // An out-of-grid result carries zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !index_valid |-> (cell_index == 22'd0) && (levels_up == 3'd0))
    else $error("invalid result with nonzero fields");

  // Reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Configuration port never back-pressures
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind octree_aabb_cell_index oaci_checker u_oaci_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_idx.valid),
  .out_ready   (out_idx.ready),
  .cell_index  (out_idx.cell_index),
  .levels_up   (out_idx.levels_up),
  .index_valid (out_idx.index_valid),
  .cfg_ready   (cfg_wr.ready)
);
